@@ hdl/rgbhsl_pkg.sv @@
`timescale 1ns / 1ps

package rgbhsl_pkg;

    // Default fraction width of the results
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 17;
    localparam int LIT_W  = 17;
    localparam int FLD_W  = HUE_W + SAT_W + LIT_W;
    localparam int M_TDATA_W = ((FLD_W + 7) / 8) * 8;
    localparam int PAD_W  = M_TDATA_W - FLD_W;

    // Divider remainder width: the largest divisor is 6 * 255 = 1530
    localparam int REM_W  = 11;
    localparam logic [REM_W-1:0] LIT_DEN = REM_W'(510);
    localparam logic [REM_W-1:0] HALF_SUM = REM_W'(255);

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    // One restoring division step: quotient bit on top, new remainder below
    function automatic logic [REM_W:0] div_step(input logic [REM_W:0] part,
                                                input logic [REM_W-1:0] den);
        logic [REM_W:0] diff;
        diff = part - {1'b0, den};
        if (part >= {1'b0, den}) begin
            div_step = {1'b1, diff[REM_W-1:0]};
        end else begin
            div_step = {1'b0, part[REM_W-1:0]};
        end
    endfunction

endpackage

@@ hdl/rgb_to_hsl_converter.sv @@
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the skid register is free; hue and saturation
// quotients are formed one bit per pipeline stage (FRAC_BITS + 1 stages) behind three
// pixel stages; lightness is a constant reciprocal multiply in the first divider stage
// and rides along after it. A one-word skid register on the output takes a refused result,
// so the pipe moves on; while that word waits in it, the pipe stalls and s_tready is low.
// Reset (aresetn low, synchronous) clears all valid bits and the skid flag; data is not reset.
module rgb_to_hsl_converter #(
    parameter int FRAC_BITS = rgbhsl_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rgbhsl_pkg::PIX_W-1:0]       s_tdata,   // pixel[23:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rgbhsl_pkg::M_TDATA_W-1:0]   m_tdata    // hue[15:0], saturation[32:16],
                                                          // lightness[49:33], zero pad
);
    import rgbhsl_pkg::*;

    localparam int QW = FRAC_BITS + 1;   // quotient bits: one integer bit plus fraction
    localparam int NS = QW + 3;          // total pipeline stages

    // Lightness: floor(sum * 2^FRAC_BITS / 510) as sum * ceil(2^(FRAC_BITS+18) / 510) >> 18,
    // exact for every sum up to 510
    localparam int LIT_SH = 18;
    localparam int LM_W   = FRAC_BITS + 10;
    localparam int LP_W   = LM_W + REM_W;
    localparam logic [LM_W-1:0] LIT_MUL =
        LM_W'(((64'd1 << (FRAC_BITS + LIT_SH)) + 64'(LIT_DEN) - 64'd1) / 64'(LIT_DEN));

    // Pipe control
    logic          en;
    logic [NS-1:0] vld_reg;
    logic          skid_full_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;

    // Stage 1: channels
    logic [CH_W-1:0] r1_reg, g1_reg, b1_reg;

    // Stage 2: max, min and which channel won
    logic [CH_W-1:0] r2_reg, g2_reg, b2_reg, mx2_reg, mn2_reg;
    max_sel_t        sel2_reg;
    logic [CH_W-1:0] mx2_next, mn2_next;
    max_sel_t        sel2_next;

    // Stage 3: numerators and divisors
    logic [REM_W-1:0] hn3_reg, hd3_reg, sn3_reg, sd3_reg, ln3_reg;
    logic [REM_W-1:0] hn3_next, hd3_next, sn3_next, sd3_next, ln3_next;
    logic [CH_W-1:0]  delta;
    logic [REM_W-1:0] delta_w, sum_w, den6;

    // Divider stages
    logic [REM_W-1:0] hrem_reg [QW];
    logic [REM_W-1:0] srem_reg [QW];
    logic [REM_W-1:0] hd_reg   [QW];
    logic [REM_W-1:0] sd_reg   [QW];
    logic [QW-1:0]    hq_reg   [QW];
    logic [QW-1:0]    sq_reg   [QW];
    logic [LIT_W-1:0] lit_reg  [QW];
    logic [REM_W-1:0] hrem_next [QW];
    logic [REM_W-1:0] srem_next [QW];
    logic [REM_W-1:0] hd_next   [QW];
    logic [REM_W-1:0] sd_next   [QW];
    logic [QW-1:0]    hq_next   [QW];
    logic [QW-1:0]    sq_next   [QW];
    logic [LIT_W-1:0] lit_next  [QW];
    logic [LP_W-1:0]  lit_prod;

    logic [M_TDATA_W-1:0] out_word;

    // Pipe moves whenever the skid register is free
    assign en       = !skid_full_reg;
    assign s_tready = en;

    // Valid bits and skid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            skid_full_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[NS-2:0], s_tvalid};
            end
            if (skid_full_reg) begin
                if (m_tready) begin
                    skid_full_reg <= 1'b0;
                end
            end else if (vld_reg[NS-1] && !m_tready) begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    // Skid data capture
    always_ff @(posedge aclk) begin
        if (!skid_full_reg && vld_reg[NS-1] && !m_tready) begin
            skid_data_reg <= out_word;
        end
    end

    // Stage 2 logic: max, min, ties go red then green
    always_comb begin
        if (r1_reg >= g1_reg && r1_reg >= b1_reg) begin
            sel2_next = SEL_RED;
            mx2_next  = r1_reg;
        end else if (g1_reg >= b1_reg) begin
            sel2_next = SEL_GREEN;
            mx2_next  = g1_reg;
        end else begin
            sel2_next = SEL_BLUE;
            mx2_next  = b1_reg;
        end
        mn2_next = r1_reg;
        if (g1_reg < mn2_next) begin
            mn2_next = g1_reg;
        end
        if (b1_reg < mn2_next) begin
            mn2_next = b1_reg;
        end
    end

    // Stage 3 logic: sextant numerator and divisors
    assign delta   = mx2_reg - mn2_reg;
    assign delta_w = REM_W'(delta);
    assign sum_w   = REM_W'(mx2_reg) + REM_W'(mn2_reg);
    assign den6    = (delta_w << 2) + (delta_w << 1);

    always_comb begin
        case (sel2_reg)
            SEL_RED: begin
                if (g2_reg >= b2_reg) begin
                    hn3_next = REM_W'(g2_reg) - REM_W'(b2_reg);
                end else begin
                    hn3_next = den6 - (REM_W'(b2_reg) - REM_W'(g2_reg));
                end
            end
            SEL_GREEN: hn3_next = (delta_w << 1) + REM_W'(b2_reg) - REM_W'(r2_reg);
            SEL_BLUE:  hn3_next = (delta_w << 2) + REM_W'(r2_reg) - REM_W'(g2_reg);
            default:   hn3_next = '0;
        endcase
        sn3_next = delta_w;
        ln3_next = sum_w;
        // achromatic: zero numerators over a unit divisor give zero
        if (delta == '0) begin
            hn3_next = '0;
            hd3_next = REM_W'(1);
            sd3_next = REM_W'(1);
        end else begin
            hd3_next = den6;
            sd3_next = (sum_w <= HALF_SUM) ? sum_w : LIT_DEN - sum_w;
        end
    end

    // Lightness product, taken in the first divider stage
    assign lit_prod = LP_W'(ln3_reg) * LP_W'(LIT_MUL);

    // Divider steps: stage 0 yields the integer bit, later ones a fraction bit each
    always_comb begin
        logic [REM_W:0] hres, sres;
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                hres = div_step({1'b0, hn3_reg}, hd3_reg);
                sres = div_step({1'b0, sn3_reg}, sd3_reg);
                hd_next[j]  = hd3_reg;
                sd_next[j]  = sd3_reg;
                hq_next[j]  = QW'(hres[REM_W]);
                sq_next[j]  = QW'(sres[REM_W]);
                lit_next[j] = LIT_W'(lit_prod >> LIT_SH);
            end else begin
                hres = div_step({hrem_reg[j-1], 1'b0}, hd_reg[j-1]);
                sres = div_step({srem_reg[j-1], 1'b0}, sd_reg[j-1]);
                hd_next[j]  = hd_reg[j-1];
                sd_next[j]  = sd_reg[j-1];
                hq_next[j]  = {hq_reg[j-1][QW-2:0], hres[REM_W]};
                sq_next[j]  = {sq_reg[j-1][QW-2:0], sres[REM_W]};
                lit_next[j] = lit_reg[j-1];
            end
            hrem_next[j] = hres[REM_W-1:0];
            srem_next[j] = sres[REM_W-1:0];
        end
    end

    // Pipeline data registers
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= s_tdata[CH_W-1:0];
            g1_reg   <= s_tdata[2*CH_W-1:CH_W];
            b1_reg   <= s_tdata[3*CH_W-1:2*CH_W];
            r2_reg   <= r1_reg;
            g2_reg   <= g1_reg;
            b2_reg   <= b1_reg;
            mx2_reg  <= mx2_next;
            mn2_reg  <= mn2_next;
            sel2_reg <= sel2_next;
            hn3_reg  <= hn3_next;
            hd3_reg  <= hd3_next;
            sn3_reg  <= sn3_next;
            sd3_reg  <= sd3_next;
            ln3_reg  <= ln3_next;
            for (int j = 0; j < QW; j++) begin
                hrem_reg[j] <= hrem_next[j];
                srem_reg[j] <= srem_next[j];
                hd_reg[j]   <= hd_next[j];
                sd_reg[j]   <= sd_next[j];
                hq_reg[j]   <= hq_next[j];
                sq_reg[j]   <= sq_next[j];
                lit_reg[j]  <= lit_next[j];
            end
        end
    end

    // Result word from the last stage, cut to the field widths
    assign out_word = {{PAD_W{1'b0}},
                       lit_reg[QW-1],
                       SAT_W'(sq_reg[QW-1]),
                       HUE_W'(hq_reg[QW-1])};

    assign m_tvalid = skid_full_reg || vld_reg[NS-1];
    assign m_tdata  = skid_full_reg ? skid_data_reg : out_word;

endmodule

@@ bench/rgb_to_hsl_converter_tb.sv @@
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
    import rgbhsl_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LATENCY   = FRAC + 4;

    // One converted color, in the field order of m_tdata
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [LIT_W-1:0] lit;
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hsl_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [PIX_W-1:0] pixel_q[$];
    hsl_t             hsl_q[$];

    int send_idle_pct = 16;
    int recv_idle_pct = 83;
    int errors        = 0;
    int n_pixels      = 0;
    int n_results     = 0;
    int n_gray        = 0;
    int max_cnt[3]    = '{0, 0, 0};

    rgb_to_hsl_converter #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pack three channel bytes into a pixel word
    function automatic logic [PIX_W-1:0] rgb(input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b);
        return {b, g, r};
    endfunction

    // Channel holding the maximum, ties going red, then green
    function automatic max_sel_t max_channel(input logic [PIX_W-1:0] px);
        logic [CH_W-1:0] r, g, b;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        if (r >= g && r >= b) begin
            return SEL_RED;
        end else if (g >= b) begin
            return SEL_GREEN;
        end
        return SEL_BLUE;
    endfunction

    // Exact integer HSL of one pixel
    function automatic hsl_t predict_hsl(input logic [PIX_W-1:0] px);
        longint unsigned r, g, b, mx, mn, dl, sm, den, n, one;
        hsl_t res;
        r   = px[7:0];
        g   = px[15:8];
        b   = px[23:16];
        one = 64'd1 << FRAC;
        mx  = (r > g) ? r : g;
        mx  = (b > mx) ? b : mx;
        mn  = (r < g) ? r : g;
        mn  = (b < mn) ? b : mn;
        dl  = mx - mn;
        sm  = mx + mn;
        res = '0;
        res.lit = LIT_W'((sm * one) / 510);
        if (dl != 0) begin
            den = (sm <= 255) ? sm : 510 - sm;
            res.sat = SAT_W'((dl * one) / den);
            case (max_channel(px))
                SEL_RED:   n = (g >= b) ? g - b : 6 * dl - (b - g);
                SEL_GREEN: n = 2 * dl + b - r;
                default:   n = 4 * dl + r - g;
            endcase
            res.hue = HUE_W'((n * one) / (6 * dl));
        end
        return res;
    endfunction

    // Random pixel, biased toward ties, grays and the channel extremes
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [CH_W-1:0] ch[3];
        int mode;
        mode = $urandom_range(5);
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(3))
                0:       ch[i] = 8'd0;
                1:       ch[i] = 8'd255;
                default: ch[i] = CH_W'($urandom);
            endcase
        end
        case (mode)
            0, 1, 2: return PIX_W'($urandom);
            3:       return rgb(ch[0], ch[1], ch[2]);
            4:       return rgb(ch[0], ch[0], ch[0]);
            default: begin
                // two channels equal, third anywhere
                ch[$urandom_range(2)] = ch[$urandom_range(2)];
                return rgb(ch[0], ch[1], ch[2]);
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_tvalid || hsl_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Pixel driver: takes the next word from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                hsl_q.push_back(predict_hsl(s_tdata));
                n_pixels++;
                max_cnt[int'(max_channel(s_tdata))]++;
                if (s_tdata[7:0] == s_tdata[15:8] && s_tdata[7:0] == s_tdata[23:16]) begin
                    n_gray++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each word against the oldest prediction
    always @(posedge aclk) begin
        hsl_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = hsl_t'(m_tdata);
                n_results++;
                if (hsl_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = hsl_q.pop_front();
                    check_field("hue", 32'(want.hue), 32'(got.hue));
                    check_field("saturation", 32'(want.sat), 32'(got.sat));
                    check_field("lightness", 32'(want.lit), 32'(got.lit));
                    check_field("pad", 32'(want.pad), 32'(got.pad));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, grays, ties, lightness boundary, hue wrap
        pixel_q.push_back(rgb(8'd0, 8'd0, 8'd0));
        pixel_q.push_back(rgb(8'd255, 8'd255, 8'd255));
        pixel_q.push_back(rgb(8'd128, 8'd128, 8'd128));
        pixel_q.push_back(rgb(8'd127, 8'd127, 8'd127));
        pixel_q.push_back(rgb(8'd255, 8'd0, 8'd0));
        pixel_q.push_back(rgb(8'd0, 8'd255, 8'd0));
        pixel_q.push_back(rgb(8'd0, 8'd0, 8'd255));
        pixel_q.push_back(rgb(8'd255, 8'd255, 8'd0));
        pixel_q.push_back(rgb(8'd0, 8'd255, 8'd255));
        pixel_q.push_back(rgb(8'd255, 8'd0, 8'd255));
        pixel_q.push_back(rgb(8'd255, 8'd0, 8'd1));
        pixel_q.push_back(rgb(8'd255, 8'd1, 8'd0));
        pixel_q.push_back(rgb(8'd1, 8'd0, 8'd0));
        pixel_q.push_back(rgb(8'd255, 8'd254, 8'd254));
        pixel_q.push_back(rgb(8'd128, 8'd127, 8'd127));
        pixel_q.push_back(rgb(8'd200, 8'd56, 8'd100));
        pixel_q.push_back(rgb(8'd129, 8'd127, 8'd200));
        pixel_q.push_back(rgb(8'd10, 8'd200, 8'd90));
        pixel_q.push_back(rgb(8'd90, 8'd30, 8'd250));
        pixel_q.push_back(rgb(8'd254, 8'd255, 8'd1));
        pixel_q.push_back(24'hAAAAAA);
        pixel_q.push_back(24'h555555);

        // sender idles lightly, receiver stalls hard
        for (int i = 0; i < 230; i++) pixel_q.push_back(rand_pixel());
        wait_drained();

        // the other way round
        send_idle_pct = 83;
        recv_idle_pct = 16;
        for (int i = 0; i < 260; i++) pixel_q.push_back(rand_pixel());
        wait_drained();

        // full rate both sides, with a drained pause halfway
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 130; i++) pixel_q.push_back(rand_pixel());
        wait_drained();
        for (int i = 0; i < 130; i++) pixel_q.push_back(rand_pixel());
        wait_drained();

        repeat (LATENCY + 10) @(posedge aclk);
        if (hsl_q.size() != 0) begin
            errors++;
            $display("%0t: %0d predicted results never arrived", $time, hsl_q.size());
        end

        $display("Converted %0d pixels, %0d results checked, %0d gray", n_pixels,
                 n_results, n_gray);
        $display("Max channel counts: red %0d, green %0d, blue %0d; %0d mismatches",
                 max_cnt[0], max_cnt[1], max_cnt[2], errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
